// ===== src/image_median_filter_assert.svh =====
// Assertion macros for the image median filter.
// Used by the controller; no other dependencies.
`ifndef IMAGE_MEDIAN_FILTER_ASSERT_SVH
`define IMAGE_MEDIAN_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define IMF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("imf assertion failed");
`define IMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
    else $error("imf assertion failed");
`else
`define IMF_ASSERT(label, clk, rst, prop)
`define IMF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/imf_pkg.sv =====
// Shared types and constants of the image median filter.
// Beat payloads, register indexes and controller/datapath handshake structs.
`timescale 1ns / 1ps
package imf_pkg;

  localparam int CH_W   = 8;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 11;

  localparam logic [CFG_AW-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd2;
  localparam logic [CFG_AW-1:0] REG_COLOR  = 2'd3;

  localparam int RADIUS_RST = 2;
  localparam int WIDTH_RST  = 1024;
  localparam int HEIGHT_RST = 1024;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_last;
  } pixel_out_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic fetch;
    logic scan;
    logic resolve;
    logic out_load;
  } imf_cmd_t;

  typedef struct packed {
    logic emit;
    logic walk_last;
    logic fetch_last;
    logic scan_last;
    logic plane_last;
    logic out_free;
  } imf_sts_t;

endpackage

// ===== src/imf_ctrl.sv =====
// Sequencer of the image median filter: walks one item through store,
// window fetch, eight bit-plane scans and result hand-off. Uses imf_pkg.
`timescale 1ns / 1ps
`include "image_median_filter_assert.svh"
module imf_ctrl import imf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  imf_sts_t sts,
  output imf_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_WALK    = 7'b0000010,
    S_FETCH   = 7'b0000100,
    S_FLUSH   = 7'b0001000,
    S_SCAN    = 7'b0010000,
    S_RESOLVE = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.emit) state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_last) state_next = S_FETCH;
        else cmd.walk = 1'b1;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (sts.fetch_last) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = sts.plane_last ? S_EMIT : S_SCAN;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `IMF_ASSERT(a_load_when_free, clk, rst, cmd.out_load |-> sts.out_free)
  `IMF_ASSERT_NEXT(a_walk_to_fetch, clk, rst, (state == S_WALK && sts.walk_last),
                   (state == S_FETCH))
  `IMF_ASSERT_NEXT(a_last_plane_emit, clk, rst, (state == S_RESOLVE && sts.plane_last),
                   (state == S_EMIT))

endmodule

// ===== src/imf_datapath.sv =====
// Datapath of the image median filter: config registers, line store ring,
// window address walk, sample buffer and radix median select. Uses imf_pkg.
`timescale 1ns / 1ps
module imf_datapath import imf_pkg::*; #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  input  pixel_in_t         in_data,
  input  imf_cmd_t          cmd,
  output imf_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output pixel_out_t        out_data
);

  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int DEPTH    = SIDE_MAX * MAX_WIDTH;
  localparam int WIN_MAX  = SIDE_MAX * SIDE_MAX;
  localparam int AW   = $clog2(DEPTH);
  localparam int DW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RWD  = $clog2(MAX_HEIGHT);
  localparam int RADW = $clog2(MAX_RADIUS + 1);
  localparam int SW   = $clog2(WIN_MAX);
  localparam int NW   = $clog2(WIN_MAX + 1);
  localparam int LW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int DYW  = RADW + 1;
  localparam int RPW  = RWD + 2;
  localparam int CPW  = CW + 2;
  localparam int PIX_W = 3 * CH_W;

  localparam logic [RADW-1:0] RAD_INIT =
    RADW'(RADIUS_RST > MAX_RADIUS ? MAX_RADIUS : RADIUS_RST);
  localparam logic [DW-1:0] WID_INIT = DW'(WIDTH_RST > MAX_WIDTH ? MAX_WIDTH : WIDTH_RST);
  localparam logic [HW-1:0] HGT_INIT =
    HW'(HEIGHT_RST > MAX_HEIGHT ? MAX_HEIGHT : HEIGHT_RST);

  // configuration
  logic [RADW-1:0] radius;
  logic [DW-1:0]   width;
  logic [HW-1:0]   height;
  logic            color_mode;
  logic [RADW-1:0] rad_wr;
  logic [DW-1:0]   wid_wr;
  logic [HW-1:0]   hgt_wr;

  // frame position
  logic [LW-1:0]  lag_cnt;
  logic [LW-1:0]  lag_val;
  logic [HW-1:0]  write_row;
  logic [CW-1:0]  write_col;
  logic [AW-1:0]  wr_ptr;
  logic [RWD-1:0] out_row;
  logic [CW-1:0]  out_col;
  logic [AW-1:0]  out_base;
  logic           emit;
  logic           is_last;
  logic           mem_we;
  logic           restart;

  // window walk
  logic signed [DYW-1:0] rad_s;
  logic signed [DYW-1:0] dy;
  logic signed [DYW-1:0] dx;
  logic signed [RPW-1:0] row_pos;
  logic [RPW-1:0]        rp_inc;
  logic                  row_adv;
  logic [RWD-1:0]        yy_cur;
  logic [AW-1:0]         base_cur;
  logic [AW-1:0]         base_minus_w;
  logic [AW-1:0]         base_plus_w;
  logic [AW-1:0]         out_base_plus_w;
  logic [AW:0]           sum_tmp;
  logic [AW:0]           osum_tmp;
  logic signed [CPW-1:0] col_pos;
  logic [CW-1:0]         xx;
  logic [AW:0]           addr_sum;
  logic [AW-1:0]         rd_addr;

  // store and samples
  logic [PIX_W-1:0] line_mem [DEPTH];
  logic [PIX_W-1:0] samp_mem [WIN_MAX];
  logic [PIX_W-1:0] rdata;
  logic [PIX_W-1:0] sdata;
  logic             fetch_v;
  logic             scan_v;
  logic [SW-1:0]    samp_wi;
  logic [SW-1:0]    scan_i;

  // median select
  logic [RADW:0]   side;
  logic [NW-1:0]   n_samp;
  logic [NW-1:0]   rank;
  logic [2:0]      plane;
  logic [CH_W-1:0] mask;
  logic [CH_W-1:0] res   [3];
  logic [NW-1:0]   kval  [3];
  logic [NW-1:0]   cnt   [3];
  logic [NW-1:0]   tot   [3];
  logic [CH_W-1:0] sch   [3];
  logic            hit   [3];

  always_comb begin
    rad_wr = (cfg_data[1:0] > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(cfg_data[1:0]);
    if (cfg_data == '0) wid_wr = DW'(1);
    else if (cfg_data > MAX_WIDTH) wid_wr = DW'(MAX_WIDTH);
    else wid_wr = DW'(cfg_data);
    if (cfg_data == '0) hgt_wr = HW'(1);
    else if (cfg_data > MAX_HEIGHT) hgt_wr = HW'(MAX_HEIGHT);
    else hgt_wr = HW'(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= RAD_INIT;
      width      <= WID_INIT;
      height     <= HGT_INIT;
      color_mode <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_RADIUS: radius     <= rad_wr;
        REG_WIDTH:  width      <= wid_wr;
        REG_HEIGHT: height     <= hgt_wr;
        REG_COLOR:  color_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lag_val = LW'(radius) * LW'(width) + LW'(radius);
  assign emit    = (lag_cnt == lag_val);
  assign is_last = ((HW + 1)'(out_row) + 1'b1 >= (HW + 1)'(height)) &&
                   ((CW + 1)'(out_col) + 1'b1 >= (CW + 1)'(width));
  assign mem_we  = cmd.load && (write_row < height);
  assign restart = cfg_write || (cmd.out_load && is_last);

  assign osum_tmp        = {1'b0, out_base} + (AW + 1)'(width);
  assign out_base_plus_w = (osum_tmp >= DEPTH) ? AW'(osum_tmp - DEPTH) : AW'(osum_tmp);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      lag_cnt   <= '0;
      write_row <= '0;
      write_col <= '0;
      wr_ptr    <= '0;
      out_row   <= '0;
      out_col   <= '0;
      out_base  <= '0;
    end else if (cmd.load) begin
      if (!emit) lag_cnt <= lag_cnt + 1'b1;
      if (mem_we) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        if ((CW + 1)'(write_col) + 1'b1 >= (CW + 1)'(width)) begin
          write_col <= '0;
          write_row <= write_row + 1'b1;
        end else begin
          write_col <= write_col + 1'b1;
        end
      end
    end else if (cmd.out_load) begin
      if ((CW + 1)'(out_col) + 1'b1 >= (CW + 1)'(width)) begin
        out_col  <= '0;
        out_row  <= out_row + 1'b1;
        out_base <= out_base_plus_w;
      end else begin
        out_col <= out_col + 1'b1;
      end
    end
  end

  assign rad_s = $signed({1'b0, radius});

  assign sum_tmp      = {1'b0, base_cur} + (AW + 1)'(width);
  assign base_plus_w  = (sum_tmp >= DEPTH) ? AW'(sum_tmp - DEPTH) : AW'(sum_tmp);
  assign base_minus_w = (base_cur >= AW'(width)) ? base_cur - AW'(width)
                                                 : AW'(DEPTH) - AW'(width) + base_cur;

  assign rp_inc  = row_pos + 1'b1;
  assign row_adv = !row_pos[RPW-1] && (rp_inc < RPW'(height));

  always_comb begin
    col_pos = $signed({2'b00, out_col}) + CPW'(dx);
    if (col_pos[CPW-1]) xx = '0;
    else if (CPW'(col_pos) >= CPW'(width)) xx = CW'(width - 1'b1);
    else xx = col_pos[CW-1:0];
    addr_sum = {1'b0, base_cur} + (AW + 1)'(xx);
    rd_addr  = (addr_sum >= DEPTH) ? AW'(addr_sum - DEPTH) : AW'(addr_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dy       <= '0;
      dx       <= -rad_s;
      row_pos  <= $signed({2'b00, out_row});
      yy_cur   <= out_row;
      base_cur <= out_base;
    end else if (cmd.walk) begin
      dy      <= dy - 1'b1;
      row_pos <= row_pos - 1'b1;
      if (yy_cur != '0) begin
        yy_cur   <= yy_cur - 1'b1;
        base_cur <= base_minus_w;
      end
    end else if (cmd.fetch) begin
      if (dx == rad_s) begin
        dx      <= -rad_s;
        dy      <= dy + 1'b1;
        row_pos <= row_pos + 1'b1;
        if (row_adv) begin
          yy_cur   <= yy_cur + 1'b1;
          base_cur <= base_plus_w;
        end
      end else begin
        dx <= dx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[wr_ptr] <= {in_data.blue_in, in_data.green_in, in_data.red_in};
    if (cmd.fetch) rdata <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fetch_v) samp_mem[samp_wi] <= rdata;
    if (cmd.scan) sdata <= samp_mem[scan_i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_v <= 1'b0;
      scan_v  <= 1'b0;
    end else begin
      fetch_v <= cmd.fetch;
      scan_v  <= cmd.scan;
    end
  end

  assign side   = {radius, 1'b1};
  assign n_samp = NW'(side) * NW'(side);
  assign rank   = n_samp >> 1;
  assign mask   = CH_W'((CH_W'(8'hFF) << plane) << 1);

  assign sch[0] = sdata[CH_W-1:0];
  assign sch[1] = sdata[2*CH_W-1:CH_W];
  assign sch[2] = sdata[3*CH_W-1:2*CH_W];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hit[c] = scan_v && (((sch[c] ^ res[c]) & mask) == '0) && !sch[c][plane];
      tot[c] = cnt[c] + NW'(hit[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_wi <= '0;
      scan_i  <= '0;
      plane   <= 3'd7;
      for (int c = 0; c < 3; c++) begin
        res[c]  <= '0;
        kval[c] <= rank;
        cnt[c]  <= '0;
      end
    end else begin
      if (fetch_v) samp_wi <= samp_wi + 1'b1;
      if (cmd.scan) scan_i <= scan_i + 1'b1;
      if (cmd.resolve) begin
        scan_i <= '0;
        plane  <= plane - 1'b1;
        for (int c = 0; c < 3; c++) begin
          cnt[c] <= '0;
          if (kval[c] >= tot[c]) begin
            res[c][plane] <= 1'b1;
            kval[c]       <= kval[c] - tot[c];
          end
        end
      end else if (scan_v) begin
        for (int c = 0; c < 3; c++) cnt[c] <= tot[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.red_out    <= res[0];
      out_data.green_out  <= color_mode ? res[1] : res[0];
      out_data.blue_out   <= color_mode ? res[2] : res[0];
      out_data.frame_last <= is_last;
    end
  end

  assign sts.emit       = emit;
  assign sts.walk_last  = (dy == -rad_s);
  assign sts.fetch_last = (dx == rad_s) && (dy == rad_s);
  assign sts.scan_last  = (scan_i == SW'(n_samp - 1'b1));
  assign sts.plane_last = (plane == 3'd0);
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ===== src/image_median_filter.sv =====
// Top level of the streaming 2D median filter with edge replication.
// Instantiates imf_ctrl and imf_datapath; uses imf_pkg.
`timescale 1ns / 1ps
// Pixels enter in raster order; each result is the median of the (2R+1)^2
// window around an earlier pixel, with edges replicated, and appears R rows
// plus R pixels after it, so the source follows each frame with that many
// drain beats. An item that yields a result makes one line store read per
// window sample, n = (2R+1)^2 of them, then eight bit-plane passes over the
// sample buffer, one sample per cycle for all three channels. Items inside
// the lag are only stored. A finished result waits in the output register
// while the next beat is taken. Any register write restarts the frame; the
// line store needs no clearing.
module image_median_filter import imf_pkg::*; #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  pixel_in_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pixel_out_t        out_data
);

  imf_cmd_t cmd;
  imf_sts_t sts;

  imf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  imf_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/image_median_filter_tb.sv =====
// Self-checking testbench for image_median_filter: directed cases, then random frames.
// Expected pixels come from a behavioral window-median predictor; imports imf_pkg.
`timescale 1ns / 1ps
module image_median_filter_tb;
  import imf_pkg::*;

  localparam int STORE_DEPTH = 7 * 1024;
  localparam int SETTLE      = 600;
  localparam int IDLE_LIMIT  = 20000;

  typedef struct {
    bit               is_reg;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] val;
    pixel_in_t        px;
    bit               typed;
    pixel_out_t       res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  pixel_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  pixel_out_t out_data;

  image_median_filter u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [23:0] pix_store [STORE_DEPTH];
  int unsigned radius_q, width_q, height_q;
  bit          color_q;
  int unsigned taken, wr_row, wr_col, rd_row, rd_col;
  pixel_out_t  median_q [$];
  int          errors = 0;
  int          burst_left = 0;

  function automatic void restart_frame();
    taken = 0; wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
    case (addr)
      REG_RADIUS: radius_q = val[1:0];
      REG_WIDTH:  width_q  = val;
      REG_HEIGHT: height_q = val;
      REG_COLOR:  color_q  = val[0];
      default: ;
    endcase
    restart_frame();
  endfunction

  function automatic logic [7:0] window_median(logic [7:0] s[49], int n);
    logic [7:0] x;
    int j;
    for (int i = 1; i < n; i++) begin
      x = s[i];
      j = i;
      while (j > 0 && s[j-1] > x) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = x;
    end
    return s[n/2];
  endfunction

  function automatic int unsigned clamp_pos(int v, int unsigned lim);
    if (v < 0) return 0;
    if (v >= int'(lim)) return lim - 1;
    return v;
  endfunction

  function automatic bit predict_median(pixel_in_t p, output pixel_out_t res);
    int unsigned r, w, h, lag, yy, xx, n;
    logic [23:0] px;
    logic [7:0] sr[49], sg[49], sb[49];
    bit last;
    r = (radius_q > 3) ? 3 : radius_q;
    w = (width_q < 1) ? 1 : (width_q > 1024 ? 1024 : width_q);
    h = (height_q < 1) ? 1 : (height_q > 1024 ? 1024 : height_q);
    lag = r * w + r;
    n = 0;
    res = '0;
    if (wr_row < h) begin
      pix_store[(wr_row * w + wr_col) % STORE_DEPTH] = {p.blue_in, p.green_in, p.red_in};
      wr_col++;
      if (wr_col >= w) begin
        wr_col = 0;
        wr_row++;
      end
    end
    if (taken < lag) begin
      taken++;
      return 1'b0;
    end
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      yy = clamp_pos(int'(rd_row) + dy, h);
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        xx = clamp_pos(int'(rd_col) + dx, w);
        px = pix_store[(yy * w + xx) % STORE_DEPTH];
        sr[n] = px[7:0];
        sg[n] = px[15:8];
        sb[n] = px[23:16];
        n++;
      end
    end
    res.red_out = window_median(sr, n);
    res.green_out = color_q ? window_median(sg, n) : res.red_out;
    res.blue_out = color_q ? window_median(sb, n) : res.red_out;
    last = (rd_row + 1 >= h) && (rd_col + 1 >= w);
    res.frame_last = last;
    if (last) begin
      restart_frame();
    end else begin
      rd_col++;
      if (rd_col >= w) begin
        rd_col = 0;
        rd_row++;
      end
      taken++;
    end
    return 1'b1;
  endfunction

  task automatic wait_drained();
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= val;
    apply_reg(addr, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_pixel(pixel_in_t p, bit typed = 1'b0, pixel_out_t typed_res = '0);
    pixel_out_t res;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    if (predict_median(p, res)) median_q.push_back(typed ? typed_res : res);
  endtask

  task automatic send_frame(int unsigned r, int unsigned w, int unsigned h, int unsigned cut,
                            bit narrow, output int unsigned sent);
    pixel_in_t p;
    int unsigned total;
    logic [7:0] base;
    total = w * h + r * w + r;
    if (cut != 0 && cut < total) total = cut;
    base = 8'($urandom);
    for (int unsigned i = 0; i < total; i++) begin
      p.op = (i < w * h) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 3) != 0);
      if (narrow) begin
        p.red_in = 8'(base + $urandom_range(0, 3));
        p.green_in = 8'(base + $urandom_range(0, 3));
        p.blue_in = 8'(base + $urandom_range(0, 3));
      end else begin
        p.red_in = 8'($urandom);
        p.green_in = 8'($urandom);
        p.blue_in = 8'($urandom);
      end
      send_pixel(p);
    end
    sent = total;
  endtask

  // receiver stall pattern
  int unsigned rx_mode = 0, rx_left = 0, rx_cyc = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_cyc++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (rx_cyc % 16) < 4;
    endcase
  end

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (median_q.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        errors++;
      end else begin
        want = median_q.pop_front();
        if (out_data.red_out !== want.red_out) begin
          $error("red_out expected %0h actual %0h", want.red_out, out_data.red_out);
          errors++;
        end
        if (out_data.green_out !== want.green_out) begin
          $error("green_out expected %0h actual %0h", want.green_out, out_data.green_out);
          errors++;
        end
        if (out_data.blue_out !== want.blue_out) begin
          $error("blue_out expected %0h actual %0h", want.blue_out, out_data.blue_out);
          errors++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last expected %0b actual %0b", want.frame_last, out_data.frame_last);
          errors++;
        end
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("image_median_filter: mismatch");
        $finish;
      end
    end
  end

  stim_row_t table_rows [$];

  function automatic stim_row_t reg_row(logic [CFG_AW-1:0] a, logic [CFG_DW-1:0] v);
    stim_row_t s;
    s = '{1'b1, a, v, '0, 1'b0, '0};
    return s;
  endfunction

  function automatic stim_row_t px_row(bit op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       bit typed = 1'b0, pixel_out_t res = '0);
    stim_row_t s;
    s = '{1'b0, '0, '0, '{op, r, g, b}, typed, res};
    return s;
  endfunction

  initial begin
    int unsigned rnd_items, sent, r, w, h;
    pixel_in_t p;
    radius_q = RADIUS_RST; width_q = WIDTH_RST; height_q = HEIGHT_RST; color_q = 1'b1;
    restart_frame();

    table_rows.push_back(reg_row(REG_RADIUS, 11'd0));
    table_rows.push_back(reg_row(REG_WIDTH, 11'd1));
    table_rows.push_back(reg_row(REG_HEIGHT, 11'd1));
    table_rows.push_back(reg_row(REG_COLOR, 11'd1));
    table_rows.push_back(px_row(1'b0, 8'hff, 8'h00, 8'ha5, 1'b1, '{8'hff, 8'h00, 8'ha5, 1'b1}));
    table_rows.push_back(px_row(1'b1, 8'h12, 8'h34, 8'h56, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1}));
    table_rows.push_back(reg_row(REG_COLOR, 11'd0));
    table_rows.push_back(px_row(1'b0, 8'h80, 8'h01, 8'h7f, 1'b1, '{8'h80, 8'h80, 8'h80, 1'b1}));
    table_rows.push_back(reg_row(REG_COLOR, 11'd1));
    table_rows.push_back(reg_row(REG_RADIUS, 11'd3));
    table_rows.push_back(reg_row(REG_WIDTH, 11'd2));
    table_rows.push_back(px_row(1'b0, 8'h00, 8'hff, 8'h10));
    table_rows.push_back(px_row(1'b0, 8'hff, 8'h00, 8'h20));
    for (int i = 0; i < 9; i++)
      table_rows.push_back(px_row(i[0], 8'(8'h55 + i), 8'haa, 8'(8'hc0 + i)));
    table_rows.push_back(reg_row(REG_RADIUS, 11'd1));
    table_rows.push_back(reg_row(REG_WIDTH, 11'd0));
    table_rows.push_back(reg_row(REG_HEIGHT, 11'd0));
    table_rows.push_back(px_row(1'b0, 8'h5a, 8'hc3, 8'h3c));
    table_rows.push_back(px_row(1'b1, 8'h00, 8'h00, 8'h00));
    table_rows.push_back(px_row(1'b1, 8'hff, 8'hff, 8'hff, 1'b1, '{8'h5a, 8'hc3, 8'h3c, 1'b1}));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      if (table_rows[i].is_reg) write_reg(table_rows[i].addr, table_rows[i].val);
      else send_pixel(table_rows[i].px, table_rows[i].typed, table_rows[i].res);
    end

    // widest row, radius zero, with one pause until everything has drained
    write_reg(REG_RADIUS, 11'd0);
    write_reg(REG_WIDTH, 11'd2047);
    write_reg(REG_HEIGHT, 11'd1);
    write_reg(REG_COLOR, CFG_DW'($urandom_range(0, 1)));
    for (int i = 0; i < 1024; i++) begin
      if (i == 512) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
      end
      p = {1'(i == 700), 8'($urandom), 8'($urandom), 8'($urandom)};
      send_pixel(p);
    end

    // tallest frame, cut short
    write_reg(REG_RADIUS, 11'd1);
    write_reg(REG_WIDTH, 11'd1);
    write_reg(REG_HEIGHT, 11'd2047);
    send_frame(1, 1, 1024, 40, 1'b0, sent);

    rnd_items = 0;
    while (rnd_items < 240) begin
      r = $urandom_range(0, 3);
      w = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 6);
      h = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 5);
      write_reg(REG_RADIUS, CFG_DW'(r));
      write_reg(REG_WIDTH, CFG_DW'(w));
      write_reg(REG_HEIGHT, CFG_DW'(h));
      write_reg(REG_COLOR, CFG_DW'($urandom_range(0, 1)));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      repeat ($urandom_range(1, 2)) begin
        send_frame(r, w, h, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : 0,
                   $urandom_range(0, 2) == 0, sent);
        rnd_items += sent;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    if (errors == 0) begin
      $display("image_median_filter: match");
    end else begin
      $display("image_median_filter: mismatch");
    end
    $finish;
  end

endmodule
